// File: src/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the block bitmap allocator: status codes,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 64;

    localparam int BLK_W       = 12;
    localparam int STAT_W      = 2;
    localparam int FIELD_REACH = 4096;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_DOUBLE_FREE = 2'd1,
        STATUS_FULL        = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_HINT_RD,
        ST_HINT_CHK,
        ST_SCAN,
        ST_PICK,
        ST_SCAN_WR
    } fsm_state_t;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_HINT,
        OUT_SCAN,
        OUT_DFREE,
        OUT_FULL
    } out_sel_t;

    typedef struct packed {
        logic     clr_wr;
        logic     load;
        logic     decode;
        logic     hint_rd;
        logic     hint_wr;
        logic     scan_start;
        logic     scan_rd;
        logic     scan_pick;
        logic     scan_wr;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic req_free;
        logic in_range;
        logic hint_used;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// File: src/block_bitmap_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_bitmap_allocator_core
// First-fit block allocator with a preferred block, over a bitmap in memory.
//
// Input channel (s_valid/s_ready): s_req_type 0 allocates, preferring
// s_block_index; 1 frees s_block_index. Result channel (m_valid/m_ready):
// m_status (ok, double free, full) and m_result_block, zero unless ok.
// Every request yields exactly one result transaction.
// The preferred block decides the request when it is free, and it decides
// any free request; an allocate that falls back to the first-fit search
// reads up to ceil(min(NUM_BLOCKS,4096)/WORD_BITS) bitmap words (64 at the
// defaults). The search reads one bitmap word per cycle through the memory's
// single read port. A new request is taken in the cycle after the result is
// loaded. After reset the bitmap memory is cleared one word per cycle;
// s_ready stays low until that pass ends.
// A stalled receiver holds the result register; the next request is still
// accepted and processed, and waits before its bitmap update and result
// load until the pending result has been taken.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_core #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_req_type,
    input  wire logic [bba_pkg::BLK_W-1:0]  s_block_index,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [bba_pkg::STAT_W-1:0]      m_status,
    output logic [bba_pkg::BLK_W-1:0]       m_result_block
);
    import bba_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_req_type     (s_req_type),
        .s_block_index  (s_block_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_block (m_result_block),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
`default_nettype wire

// File: src/bba_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap word memory, request registers, hint decode, first-free search and
// the registered result stage.
// ----------------------------------------------------------------------------
module bba_datapath #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_req_type,
    input  wire logic [bba_pkg::BLK_W-1:0]   s_block_index,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [bba_pkg::STAT_W-1:0]       m_status,
    output logic [bba_pkg::BLK_W-1:0]        m_result_block,
    input  wire bba_pkg::cmd_t               cmd,
    output bba_pkg::stat_t                   stat
);
    import bba_pkg::*;

    localparam int USABLE  = (NUM_BLOCKS < FIELD_REACH) ? NUM_BLOCKS : FIELD_REACH;
    localparam int NW      = (USABLE + WORD_BITS - 1) / WORD_BITS;
    localparam int AW      = (NW > 1) ? $clog2(NW) : 1;
    localparam int BW      = $clog2(WORD_BITS);
    localparam int WB_W    = 7;
    localparam int LAST_BITS = USABLE - (NW - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
    localparam int RCP_SH  = 24;
    localparam int RCP_W   = 25;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'((2 ** RCP_SH + WORD_BITS - 1) / WORD_BITS);
    localparam int PW      = BLK_W + RCP_W;
    localparam int MW      = BLK_W + WB_W;

    logic [WORD_BITS-1:0] mem [NW];

    logic                 req_free_reg;
    logic [BLK_W-1:0]     blk_reg;
    logic [BLK_W-1:0]     q_reg;
    logic [BW-1:0]        rem_reg;
    logic [AW-1:0]        clr_ptr_reg;
    logic [AW-1:0]        scan_ptr_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [BW-1:0]        bit_reg;
    logic [BLK_W-1:0]     base_reg;
    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic [BLK_W-1:0]     m_result_block_reg;

    logic [PW-1:0]        prod;
    logic [MW-1:0]        qw;
    logic [MW-1:0]        rem_full;
    logic [MW-1:0]        base_full;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] free_vec;
    logic [BW-1:0]        pick;
    logic [WORD_BITS-1:0] hint_bit;
    logic [WORD_BITS-1:0] scan_bit;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 out_free;

    assign prod      = PW'(blk_reg) * PW'(RECIP);
    assign qw        = MW'(q_reg) * MW'(WORD_BITS);
    assign rem_full  = MW'(blk_reg) - qw;
    assign base_full = MW'(rd_idx_reg) * MW'(WORD_BITS);

    assign valid_mask = (rd_idx_reg == AW'(NW - 1)) ? LAST_MASK : {WORD_BITS{1'b1}};
    assign free_vec   = ~rd_data_reg & valid_mask;
    assign hint_bit   = WORD_BITS'(1) << rem_reg;
    assign scan_bit   = WORD_BITS'(1) << bit_reg;

    always_comb begin
        pick = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                pick = BW'(i);
            end
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.hint_rd) begin
            rd_en   = 1'b1;
            rd_addr = q_reg[AW-1:0];
        end else if (cmd.scan_start) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (cmd.scan_rd) begin
            rd_en   = 1'b1;
            rd_addr = scan_ptr_reg;
        end
        if (cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_reg;
        end else if (cmd.hint_wr) begin
            wr_en   = 1'b1;
            wr_addr = q_reg[AW-1:0];
            wr_data = req_free_reg ? (rd_data_reg & ~hint_bit) : (rd_data_reg | hint_bit);
        end else if (cmd.scan_wr) begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg;
            wr_data = rd_data_reg | scan_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_free_reg <= s_req_type;
            blk_reg      <= s_block_index;
        end
        if (cmd.decode) begin
            q_reg <= prod[RCP_SH +: BLK_W];
        end
        if (cmd.hint_rd) begin
            rem_reg <= rem_full[BW-1:0];
        end
        if (cmd.scan_start) begin
            rd_idx_reg   <= '0;
            scan_ptr_reg <= AW'(1);
        end else if (cmd.scan_rd) begin
            rd_idx_reg   <= scan_ptr_reg;
            scan_ptr_reg <= scan_ptr_reg + AW'(1);
        end
        if (cmd.scan_pick) begin
            bit_reg  <= pick;
            base_reg <= base_full[BLK_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_wr) begin
                clr_ptr_reg <= clr_ptr_reg + AW'(1);
            end
            if (cmd.out_sel != OUT_NONE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.out_sel)
            OUT_HINT: begin
                m_status_reg       <= STATUS_OK;
                m_result_block_reg <= blk_reg;
            end
            OUT_SCAN: begin
                m_status_reg       <= STATUS_OK;
                m_result_block_reg <= base_reg + BLK_W'(bit_reg);
            end
            OUT_DFREE: begin
                m_status_reg       <= STATUS_DOUBLE_FREE;
                m_result_block_reg <= '0;
            end
            OUT_FULL: begin
                m_status_reg       <= STATUS_FULL;
                m_result_block_reg <= '0;
            end
            default: begin
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    assign stat.clr_done  = (clr_ptr_reg == AW'(NW - 1));
    assign stat.req_free  = req_free_reg;
    assign stat.in_range  = ({1'b0, blk_reg} < (BLK_W + 1)'(USABLE));
    assign stat.hint_used = rd_data_reg[rem_reg];
    assign stat.scan_hit  = |free_vec;
    assign stat.scan_last = (rd_idx_reg == AW'(NW - 1));
    assign stat.out_free  = out_free;

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_block = m_result_block_reg;

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("bitmap read and write in the same cycle");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_sel != OUT_NONE) |-> out_free)
        else $error("result overwritten while held");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_rd |-> ({1'b0, scan_ptr_reg} < (AW + 1)'(NW)))
        else $error("scan read beyond bitmap");

    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STATUS_OK)) |-> (m_result_block == '0))
        else $error("nonzero block on error status");

endmodule
`default_nettype wire

// File: src/bba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the allocator: bitmap clear after reset, hint lookup,
// first-fit scan and result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire bba_pkg::stat_t stat,
    output bba_pkg::cmd_t       cmd
);
    import bba_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = ST_HINT_RD;
            end
            ST_HINT_RD: begin
                cmd.hint_rd = 1'b1;
                state_next  = ST_HINT_CHK;
            end
            ST_HINT_CHK: begin
                if (stat.req_free) begin
                    if (stat.out_free) begin
                        if (stat.in_range && stat.hint_used) begin
                            cmd.hint_wr = 1'b1;
                            cmd.out_sel = OUT_HINT;
                        end else begin
                            cmd.out_sel = OUT_DFREE;
                        end
                        state_next = ST_IDLE;
                    end
                end else if (stat.in_range && !stat.hint_used) begin
                    if (stat.out_free) begin
                        cmd.hint_wr = 1'b1;
                        cmd.out_sel = OUT_HINT;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_hit) begin
                    state_next = ST_PICK;
                end else if (stat.scan_last) begin
                    if (stat.out_free) begin
                        cmd.out_sel = OUT_FULL;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    cmd.scan_rd = 1'b1;
                end
            end
            ST_PICK: begin
                cmd.scan_pick = 1'b1;
                state_next    = ST_SCAN_WR;
            end
            ST_SCAN_WR: begin
                if (stat.out_free) begin
                    cmd.scan_wr = 1'b1;
                    cmd.out_sel = OUT_SCAN;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_DECODE))
        else $error("accepted transaction not decoded");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("ready raised while busy");

endmodule
`default_nettype wire
